>>> sv/indexed_min_heap_macros.svh
// Assertion helpers for the indexed min-heap; they use the clk and rst_n of the host module.
`ifndef INDEXED_MIN_HEAP_MACROS_SVH
`define INDEXED_MIN_HEAP_MACROS_SVH

// Same-cycle implication.
`define IMH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/imh_pkg.sv
`timescale 1ns / 1ps
package imh_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_KEY_BITS = 32;

    // Stream payload widths, padded to whole bytes, and the handle width.
    localparam int IN_W  = 48;
    localparam int OUT_W = 72;
    localparam int TH_W  = 10;

    typedef enum logic [1:0] {
        OPC_PUSH   = 2'd0,
        OPC_POP    = 2'd1,
        OPC_MODIFY = 2'd2,
        OPC_FLUSH  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_UP, S_UPC, S_POPL, S_DOWN, S_DA, S_DB, S_DC,
        S_MODP, S_MODH, S_MODQ, S_TOP, S_RES
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_ERR, OP_PUSH, OP_RD_PARENT, OP_HOLE_UP, OP_PLACE,
        OP_RD_TOP, OP_OUT, OP_RD_LAST, OP_LD_LAST, OP_RD_C, OP_LD_A, OP_LD_B,
        OP_HOLE_DOWN, OP_RD_POS, OP_LD_P, OP_LD_MOD, OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t st;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    push_full;
        logic    pop_empty;
        logic    th_bad;
        logic    pos_bad;
        logic    h_mismatch;
        logic    p_zero;
        logic    up_lt;
        logic    down_more;
        logic    down_two;
        logic    down_lt;
        logic    out_free;
    } sts_t;

endpackage

>>> sv/imh_ram.sv
`timescale 1ns / 1ps
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/imh_ctrl.sv
`timescale 1ns / 1ps
module imh_ctrl import imh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.st     = ST_OK;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OPC_PUSH:
                    begin
                        if (sts.push_full)
                        begin
                            cmd.op     = OP_ERR;
                            cmd.st     = ST_FULL;
                            state_next = S_TOP;
                        end
                        else
                        begin
                            cmd.op     = OP_PUSH;
                            state_next = S_UP;
                        end
                    end
                    OPC_POP:
                    begin
                        if (sts.pop_empty)
                        begin
                            cmd.op     = OP_ERR;
                            cmd.st     = ST_EMPTY;
                            state_next = S_TOP;
                        end
                        else
                        begin
                            cmd.op     = OP_RD_LAST;
                            state_next = S_POPL;
                        end
                    end
                    OPC_MODIFY:
                    begin
                        if (sts.th_bad)
                        begin
                            cmd.op     = OP_ERR;
                            cmd.st     = ST_BAD_HANDLE;
                            state_next = S_TOP;
                        end
                        else
                        begin
                            cmd.op     = OP_RD_POS;
                            state_next = S_MODP;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_FLUSH;
                        state_next = S_TOP;
                    end
                endcase
            end
            S_UP:
            begin
                if (sts.p_zero)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_TOP;
                end
                else
                begin
                    cmd.op     = OP_RD_PARENT;
                    state_next = S_UPC;
                end
            end
            S_UPC:
            begin
                if (sts.up_lt)
                begin
                    cmd.op     = OP_HOLE_UP;
                    state_next = S_UP;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_TOP;
                end
            end
            S_POPL:
            begin
                cmd.op     = OP_LD_LAST;
                state_next = S_DOWN;
            end
            S_DOWN:
            begin
                if (sts.down_more)
                begin
                    cmd.op     = OP_RD_C;
                    state_next = S_DA;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_TOP;
                end
            end
            S_DA:
            begin
                cmd.op     = OP_LD_A;
                state_next = sts.down_two ? S_DB : S_DC;
            end
            S_DB:
            begin
                cmd.op     = OP_LD_B;
                state_next = S_DC;
            end
            S_DC:
            begin
                if (sts.down_lt)
                begin
                    cmd.op     = OP_HOLE_DOWN;
                    state_next = S_DOWN;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_TOP;
                end
            end
            S_MODP:
            begin
                if (sts.pos_bad)
                begin
                    cmd.op     = OP_ERR;
                    cmd.st     = ST_BAD_HANDLE;
                    state_next = S_TOP;
                end
                else
                begin
                    cmd.op     = OP_LD_P;
                    state_next = S_MODH;
                end
            end
            S_MODH:
            begin
                if (sts.h_mismatch)
                begin
                    cmd.op     = OP_ERR;
                    cmd.st     = ST_BAD_HANDLE;
                    state_next = S_TOP;
                end
                else
                begin
                    cmd.op     = OP_LD_MOD;
                    state_next = sts.p_zero ? S_DOWN : S_MODQ;
                end
            end
            S_MODQ:
            begin
                if (sts.up_lt)
                begin
                    cmd.op     = OP_HOLE_UP;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DOWN;
                end
            end
            S_TOP:
            begin
                cmd.op     = OP_RD_TOP;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/imh_dp.sv
`timescale 1ns / 1ps
module imh_dp import imh_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  in_data,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data
);

    localparam int HW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + HW;

    opcode_t             op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TH_W-1:0]     th_reg, th_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       nxt_reg, nxt_next;
    logic [HW-1:0]       p_reg, p_next;
    logic [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [HW-1:0]       cur_h_reg, cur_h_next;
    logic [KEY_BITS-1:0] a_key_reg, a_key_next;
    logic [HW-1:0]       a_h_reg, a_h_next;
    logic [HW-1:0]       a_idx_reg, a_idx_next;
    status_t             status_reg, status_next;
    logic [HW-1:0]       given_reg, given_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic          h_we, h_re, p_we, p_re;
    logic [HW-1:0] h_waddr, h_raddr, p_waddr, p_raddr;
    logic [EW-1:0] h_wdata, h_rdata;
    logic [HW-1:0] p_wdata, p_rdata;

    logic [KEY_BITS-1:0] rd_key;
    logic [HW-1:0]       rd_h;
    logic [HW-1:0]       parent;
    logic [HW:0]         c1;
    logic [HW+1:0]       c2w;
    logic [HW+1:0]       cnt_w;
    logic [31:0]         top_key;
    logic [TH_W-1:0]     top_handle;

    imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    imh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_pos (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign rd_key = h_rdata[EW-1:HW];
    assign rd_h   = h_rdata[HW-1:0];
    assign parent = (p_reg - HW'(1)) >> 1;
    assign c1     = {p_reg, 1'b1};
    assign c2w    = {1'b0, p_reg, 1'b0} + (HW+2)'(2);
    assign cnt_w  = (HW+2)'(count_reg);

    assign top_key    = (count_reg != '0) ? 32'(rd_key) : 32'd0;
    assign top_handle = (count_reg != '0) ? TH_W'(rd_h) : '0;

    always_comb
    begin
        sts.op         = op_reg;
        sts.push_full  = (32'(count_reg) >= 32'(CAPACITY)) || (32'(nxt_reg) >= 32'(CAPACITY));
        sts.pop_empty  = (count_reg == '0);
        sts.th_bad     = (32'(th_reg) >= 32'(CAPACITY)) || (32'(th_reg) >= 32'(nxt_reg));
        sts.pos_bad    = (CW'(p_rdata) >= count_reg);
        sts.h_mismatch = (rd_h != HW'(th_reg));
        sts.p_zero     = (p_reg == '0);
        sts.up_lt      = (cur_key_reg < rd_key);
        sts.down_more  = ((HW+2)'(c1) < cnt_w);
        sts.down_two   = (c2w < cnt_w);
        sts.down_lt    = (a_key_reg < cur_key_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        th_next        = th_reg;
        count_next     = count_reg;
        nxt_next       = nxt_reg;
        p_next         = p_reg;
        cur_key_next   = cur_key_reg;
        cur_h_next     = cur_h_reg;
        a_key_next     = a_key_reg;
        a_h_next       = a_h_reg;
        a_idx_next     = a_idx_reg;
        status_next    = status_reg;
        given_next     = given_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        h_we    = 1'b0;
        h_waddr = p_reg;
        h_wdata = {cur_key_reg, cur_h_reg};
        h_re    = 1'b0;
        h_raddr = '0;
        p_we    = 1'b0;
        p_waddr = cur_h_reg;
        p_wdata = p_reg;
        p_re    = 1'b0;
        p_raddr = HW'(th_reg);

        case (cmd.op)
            OP_ACCEPT:
            begin
                op_next     = opcode_t'(in_data[1:0]);
                key_next    = KEY_BITS'(in_data[33:2]);
                th_next     = in_data[43:34];
                status_next = ST_OK;
                given_next  = '0;
            end
            OP_ERR:
            begin
                status_next = cmd.st;
            end
            OP_PUSH:
            begin
                cur_key_next = key_reg;
                cur_h_next   = HW'(nxt_reg);
                p_next       = HW'(count_reg);
                given_next   = HW'(nxt_reg);
                nxt_next     = nxt_reg + CW'(1);
                count_next   = count_reg + CW'(1);
            end
            OP_RD_PARENT:
            begin
                h_re    = 1'b1;
                h_raddr = parent;
            end
            OP_HOLE_UP:
            begin
                // The parent drops into the hole, and the hole climbs.
                h_we    = 1'b1;
                h_wdata = h_rdata;
                p_we    = 1'b1;
                p_waddr = rd_h;
                p_next  = parent;
            end
            OP_PLACE:
            begin
                h_we = 1'b1;
                p_we = 1'b1;
            end
            OP_RD_TOP:
            begin
                h_re = 1'b1;
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {6'd0, (count_reg == '0), 11'(count_reg), top_handle,
                                  top_key, TH_W'(given_reg), status_reg};
            end
            OP_RD_LAST:
            begin
                h_re    = 1'b1;
                h_raddr = HW'(count_reg - CW'(1));
            end
            OP_LD_LAST:
            begin
                cur_key_next = rd_key;
                cur_h_next   = rd_h;
                count_next   = count_reg - CW'(1);
                p_next       = '0;
            end
            OP_RD_C:
            begin
                h_re    = 1'b1;
                h_raddr = c1[HW-1:0];
            end
            OP_LD_A:
            begin
                a_key_next = rd_key;
                a_h_next   = rd_h;
                a_idx_next = c1[HW-1:0];
                h_re       = 1'b1;
                h_raddr    = c2w[HW-1:0];
            end
            OP_LD_B:
            begin
                if (rd_key < a_key_reg)
                begin
                    a_key_next = rd_key;
                    a_h_next   = rd_h;
                    a_idx_next = c2w[HW-1:0];
                end
            end
            OP_HOLE_DOWN:
            begin
                h_we    = 1'b1;
                h_wdata = {a_key_reg, a_h_reg};
                p_we    = 1'b1;
                p_waddr = a_h_reg;
                p_next  = a_idx_reg;
            end
            OP_RD_POS:
            begin
                p_re = 1'b1;
            end
            OP_LD_P:
            begin
                p_next  = p_rdata;
                h_re    = 1'b1;
                h_raddr = p_rdata;
            end
            OP_LD_MOD:
            begin
                cur_key_next = key_reg;
                cur_h_next   = HW'(th_reg);
                h_re         = 1'b1;
                h_raddr      = parent;
            end
            OP_FLUSH:
            begin
                count_next = '0;
                nxt_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            nxt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            nxt_reg       <= nxt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        th_reg       <= th_next;
        p_reg        <= p_next;
        cur_key_reg  <= cur_key_next;
        cur_h_reg    <= cur_h_next;
        a_key_reg    <= a_key_next;
        a_h_reg      <= a_h_next;
        a_idx_reg    <= a_idx_next;
        status_reg   <= status_next;
        given_reg    <= given_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/indexed_min_heap.sv
`timescale 1ns / 1ps
// Indexed binary min-heap with stable handles.
// Commands arrive on the s_axis side, one transaction per operation (push, pop minimum,
// modify key of a handle, flush). Each command yields exactly one result transaction on
// the m_axis side carrying status, the handle given by a push, the top key and handle,
// the entry count and an empty flag.
// Commands are handled one at a time. A sift walks one heap level per step through the
// heap memory, which has one write port and one read port: a level going up passes the
// states S_UP and S_UPC, and a level going down passes S_DOWN, S_DA, S_DB (only when
// there are two children) and S_DC.
// The result sits in an output register, so a new command is taken while the last
// result still waits. If the receiver stalls, the block finishes the next command and
// then holds until the output register frees up.
// Reset empties the heap and restarts handles at zero at once; the memories are not
// cleared, since liveness of a handle is judged from the position table and the heap.
`include "indexed_min_heap_macros.svh"
module indexed_min_heap import imh_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // opcode[1:0], key[33:2], target_handle[43:34], zero pad[47:44]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[1:0], new_handle[11:2], top_key[43:12], top_handle[53:44],
    // entry_count[64:54], heap_empty[65], zero pad[71:66]
    output logic [OUT_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;
    logic idle_cmd_ok;
    logic out_err;
    logic out_empty_pop;

    // The controller sequences each command as a chain of datapath micro-operations.
    imh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the heap and position memories, counters and the result register.
    imh_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    assign idle_cmd_ok   = (cmd.op == OP_ACCEPT) || (cmd.op == OP_NONE);
    assign out_err       = m_tvalid && (m_tdata[1:0] != ST_OK);
    assign out_empty_pop = m_tvalid && (m_tdata[1:0] == ST_EMPTY);

    // While ready for a command, the datapath must not be touching the memories.
    `IMH_ASSERT_NOW(a_idle_quiet, s_tready, idle_cmd_ok, "memory op while idle")
    // One command at a time: an accepted transaction drops ready on the next cycle.
    `IMH_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "ready stayed high")
    // A rejected command never hands out a handle.
    `IMH_ASSERT_NOW(a_err_no_handle, out_err, m_tdata[11:2] == 10'd0, "handle on error")
    // A pop on an empty heap must report the heap as empty.
    `IMH_ASSERT_NOW(a_empty_pop, out_empty_pop, m_tdata[65], "empty pop not flagged")

endmodule

>>> tb/indexed_min_heap_tb.sv
`timescale 1ns / 1ps
// Testbench for the indexed min-heap.
// A directed table runs first and covers empty-heap errors, key extremes, ties and
// stale handles. Random traffic follows in phases with different idling on each side.
// A final phase fills the heap until both handles and slots run out.
// Every command is run through a behavioral copy of the heap in the testbench when it is
// accepted. The result it predicts is queued, and each result transaction from the block
// is compared field by field with the oldest queued prediction.
module indexed_min_heap_tb;
    import imh_pkg::*;

    localparam int CAP   = DEF_CAPACITY;
    localparam int LIMIT = 3000000;

    // Laid out as on m_tdata, with the empty flag in the top bit.
    typedef struct packed {
        logic        empty;
        logic [10:0] cnt;
        logic [9:0]  thandle;
        logic [31:0] tkey;
        logic [9:0]  given;
        status_t     st;
    } heap_result_t;

    typedef struct {
        opcode_t     op;
        logic [31:0] key;
        logic [9:0]  th;
        bit          fixed;
        status_t     st;
    } cmd_row_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    // opcode[1:0], key[33:2], target_handle[43:34], zero pad[47:44]
    logic [IN_W-1:0] s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    // status[1:0], new_handle[11:2], top_key[43:12], top_handle[53:44],
    // entry_count[64:54], heap_empty[65], zero pad[71:66]
    logic [OUT_W-1:0] m_tdata;

    indexed_min_heap u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow copy of the heap, updated once per accepted command.
    logic [31:0] sh_key    [CAP];
    logic [9:0]  sh_handle [CAP];
    int          sh_pos    [CAP];
    bit          sh_live   [CAP];
    int          sh_count;
    int          sh_next;

    heap_result_t pending_results[$];
    int  mismatches;
    int  cycles;
    int  send_idle_pct;
    int  recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("indexed_min_heap verification failed");
            $finish;
        end
    end

    task automatic swap_slots(input int a, input int b);
        logic [31:0] k;
        logic [9:0]  h;
        begin
            k = sh_key[a];    h = sh_handle[a];
            sh_key[a] = sh_key[b];  sh_handle[a] = sh_handle[b];
            sh_key[b] = k;    sh_handle[b] = h;
            sh_pos[sh_handle[a]] = a;
            sh_pos[sh_handle[b]] = b;
        end
    endtask

    task automatic sift_up(input int p);
        int up;
        begin
            while (p != 0)
            begin
                up = (p - 1) >> 1;
                if (sh_key[p] < sh_key[up])
                begin
                    swap_slots(p, up);
                    p = up;
                end
                else
                    break;
            end
        end
    endtask

    task automatic sift_down(input int p);
        int c;
        begin
            while (p < sh_count)
            begin
                c = 2 * p + 1;
                if (c >= sh_count)
                    break;
                if (c + 1 < sh_count && sh_key[c + 1] < sh_key[c])
                    c = c + 1;
                if (sh_key[c] < sh_key[p])
                begin
                    swap_slots(p, c);
                    p = c;
                end
                else
                    break;
            end
        end
    endtask

    // Applies one command to the shadow heap and returns the result it must produce.
    task automatic apply_command(input opcode_t op, input logic [31:0] key,
                                 input logic [9:0] th, output heap_result_t r);
        int p;
        begin
            r = '0;
            r.st = ST_OK;
            case (op)
                OPC_PUSH:
                    if (sh_count >= CAP || sh_next >= CAP)
                        r.st = ST_FULL;
                    else
                    begin
                        sh_key[sh_count]    = key;
                        sh_handle[sh_count] = sh_next[9:0];
                        sh_pos[sh_next]     = sh_count;
                        sh_live[sh_next]    = 1'b1;
                        r.given = sh_next[9:0];
                        sh_next++;
                        sh_count++;
                        sift_up(sh_count - 1);
                    end
                OPC_POP:
                    if (sh_count == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        sh_live[sh_handle[0]] = 1'b0;
                        sh_key[0]    = sh_key[sh_count - 1];
                        sh_handle[0] = sh_handle[sh_count - 1];
                        sh_pos[sh_handle[0]] = 0;
                        sh_count--;
                        sift_down(0);
                    end
                OPC_MODIFY:
                    if (int'(th) >= sh_next || !sh_live[th])
                        r.st = ST_BAD_HANDLE;
                    else
                    begin
                        p = sh_pos[th];
                        if (p < sh_count)
                        begin
                            sh_key[p] = key;
                            if (p > 0 && key < sh_key[(p - 1) >> 1])
                                sift_up(p);
                            else
                                sift_down(p);
                        end
                    end
                default:
                begin
                    sh_count = 0;
                    sh_next  = 0;
                    foreach (sh_live[i])
                        sh_live[i] = 1'b0;
                end
            endcase
            if (sh_count > 0)
            begin
                r.tkey    = sh_key[0];
                r.thandle = sh_handle[0];
            end
            r.cnt   = sh_count[10:0];
            r.empty = (sh_count == 0);
        end
    endtask

    // Offers one command, honoring the sender idle rate, and queues its prediction
    // once the transaction completes.
    task automatic send_command(input opcode_t op, input logic [31:0] key,
                                input logic [9:0] th, input bit fixed,
                                input status_t fixed_st);
        heap_result_t r;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'd0, th, key, op};
            do
                @(posedge clk);
            while (!s_tready);
            apply_command(op, key, th, r);
            if (fixed)
                r.st = fixed_st;
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    task automatic send_random;
        opcode_t     op;
        logic [31:0] key;
        logic [9:0]  th;
        int          w;
        begin
            w = $urandom_range(99);
            if (w < 45)
                op = OPC_PUSH;
            else if (w < 70)
                op = OPC_POP;
            else if (w < 97)
                op = OPC_MODIFY;
            else
                op = OPC_FLUSH;
            // Narrow keys give plenty of ties; wide ones exercise every key bit.
            key = ($urandom_range(1)) ? $urandom : $urandom_range(15);
            if (sh_next > 0 && $urandom_range(99) < 80)
                th = 10'($urandom_range(sh_next - 1));
            else
                th = 10'($urandom);
            send_command(op, key, th, 1'b0, ST_OK);
        end
    endtask

    task automatic drain;
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Receiver side: stall at the current rate and check every result transaction.
    always @(posedge clk)
    begin
        heap_result_t got;
        heap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[65:0];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch st %0d/%0d nh %0d/%0d k %h/%h th %0d/%0d n %0d/%0d e %b/%b",
                                 want.st, got.st, want.given, got.given, want.tkey, got.tkey,
                                 want.thandle, got.thandle, want.cnt, got.cnt,
                                 want.empty, got.empty);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    cmd_row_t directed[$];

    initial
    begin
        mismatches     = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        sh_count = 0;
        sh_next  = 0;
        foreach (sh_live[i])
            sh_live[i] = 1'b0;

        // Errors on an empty heap, both key extremes, a tie, decrease and increase of a
        // key, modify of stale and never-issued handles, and flush.
        directed = '{
            '{OPC_POP,    32'h0,        10'd0,    1, ST_EMPTY},
            '{OPC_MODIFY, 32'h5,        10'd0,    1, ST_BAD_HANDLE},
            '{OPC_MODIFY, 32'h5,        10'd1023, 1, ST_BAD_HANDLE},
            '{OPC_PUSH,   32'hFFFFFFFF, 10'd0,    1, ST_OK},
            '{OPC_PUSH,   32'h0,        10'd0,    1, ST_OK},
            '{OPC_PUSH,   32'h7,        10'd0,    0, ST_OK},
            '{OPC_PUSH,   32'h7,        10'd0,    0, ST_OK},
            '{OPC_MODIFY, 32'h3,        10'd0,    0, ST_OK},
            '{OPC_MODIFY, 32'hFFFFFFFE, 10'd1,    0, ST_OK},
            '{OPC_MODIFY, 32'h1,        10'd5,    1, ST_BAD_HANDLE},
            '{OPC_POP,    32'h0,        10'd0,    0, ST_OK},
            '{OPC_MODIFY, 32'h9,        10'd0,    0, ST_OK},
            '{OPC_POP,    32'h0,        10'd0,    0, ST_OK},
            '{OPC_POP,    32'h0,        10'd0,    0, ST_OK},
            '{OPC_POP,    32'h0,        10'd0,    0, ST_OK},
            '{OPC_POP,    32'h0,        10'd0,    1, ST_EMPTY},
            '{OPC_MODIFY, 32'h0,        10'd2,    1, ST_BAD_HANDLE},
            '{OPC_FLUSH,  32'hFFFFFFFF, 10'd1023, 1, ST_OK},
            '{OPC_MODIFY, 32'h0,        10'd0,    1, ST_BAD_HANDLE},
            '{OPC_PUSH,   32'h12345678, 10'd0,    0, ST_OK},
            '{OPC_FLUSH,  32'h0,        10'd0,    1, ST_OK}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_command(directed[i].op, directed[i].key, directed[i].th,
                         directed[i].fixed, directed[i].st);
        drain();

        // Random phases; the sender waits for every result between them.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            repeat (200)
                send_random();
            drain();
        end

        // Fill until handles and slots run out, then poke the full heap.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_command(OPC_FLUSH, 32'h0, 10'd0, 1, ST_OK);
        repeat (1030)
            send_command(OPC_PUSH, $urandom, 10'd0, 0, ST_OK);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        repeat (150)
            send_random();
        drain();

        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("indexed_min_heap verification clean");
        else
            $display("indexed_min_heap verification failed");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/imh_pkg.sv
sv/imh_ram.sv
sv/imh_ctrl.sv
sv/imh_dp.sv
sv/indexed_min_heap.sv
tb/indexed_min_heap_tb.sv
